/* rtl/tdpq_pkg.sv */
package tdpq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int PAYLOAD_BITS_DEFAULT = 32;
  localparam int ID_W = 64;
  localparam int CYC_W = 64;
  localparam int CAP_W = 5;
  localparam int DLY_W = 10;

  typedef enum logic [2:0] {
    FN_TICK      = 3'd0,
    FN_PUSH_DEF  = 3'd1,
    FN_PUSH_LAT  = 3'd2,
    FN_POP_OLD   = 3'd3,
    FN_POP_RDY   = 3'd4,
    FN_POP_NOW   = 3'd5,
    FN_POP_YOUNG = 3'd6,
    FN_FLUSH     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_POP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    QS_EMPTY = 2'd0,
    QS_PART  = 2'd1,
    QS_FULL  = 2'd2
  } qstate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FLUSH,
    S_FLAGS,
    S_OUT
  } state_t;

  localparam logic [0:0] REG_CAP = 1'b0;
  localparam logic [0:0] REG_DLY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic op_push;
    logic op_tick;
    logic scan_clr;   // restart scan pointer
    logic scan_step;  // examine entry at ptr
    logic shift_step; // move entry ptr+1 down
    logic shift_done; // drop count after close
    logic flush_step; // drop tail entry
    logic set_no_pop;
    logic set_full;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  empty;
    logic  full;
    logic  scan_end;
    logic  hit;
    logic  shift_end;
    logic  flush_hit;
  } sts_t;

endpackage

/* rtl/tdpq_if.sv */
interface tdpq_in_if;
  import tdpq_pkg::*;
  logic            valid;
  logic            ready;
  logic [2:0]      func;
  logic [31:0]     payload;
  logic [63:0]     seq_id;
  logic [9:0]      latency;
  modport source(output valid, func, payload, seq_id, latency, input ready);
  modport sink(input valid, func, payload, seq_id, latency, output ready);
endinterface

interface tdpq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_payload;
  logic [63:0] out_seq_id;
  logic [1:0]  status;
  logic [4:0]  occupancy;
  logic [1:0]  queue_state;
  logic        oldest_ready;
  logic        oldest_ready_now;
  logic        some_ready;
  logic        some_ready_now;
  logic [4:0]  removed_count;
  modport source(output valid, out_payload, out_seq_id, status, occupancy, queue_state,
    oldest_ready, oldest_ready_now, some_ready, some_ready_now, removed_count,
    input ready);
  modport sink(input valid, out_payload, out_seq_id, status, occupancy, queue_state,
    oldest_ready, oldest_ready_now, some_ready, some_ready_now, removed_count,
    output ready);
endinterface

/* rtl/timed_delay_port_queue.sv */
// channel | dir | payload
// in      | in  | func, payload, seq_id, latency
// out     | out | out_payload, out_seq_id, status, occupancy, flags, removed_count
// cfg     | in  | capacity_in_use (0x0), default_delay (0x4)
// One word at a time: each word runs its step (tick, push, a pop's single-slot walk
// over the entry store and shift-down, or a flush that drops tail entries) and then
// the ready-flag pass over the entries held. The result waits while out.ready is low.
// Reset (rst, synchronous) empties the queue and clears the cycle counter.
// in.ready is low while a word is in work or its result waits on out.ready.
module timed_delay_port_queue #(
  parameter int DEPTH = tdpq_pkg::DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = tdpq_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  tdpq_in_if.sink     in,
  tdpq_out_if.source  out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tdpq_pkg::*;

  logic [4:0] capacity_in_use;
  logic [9:0] default_delay;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= 5'd16;
      default_delay <= 10'd1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_CAP) capacity_in_use <= pwdata[4:0];
      else default_delay <= pwdata[9:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAP) prdata = 32'(capacity_in_use);
    else prdata = 32'(default_delay);
  end

  tdpq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .sts, .cmd
  );

  tdpq_dp #(.DEPTH(DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
    .clk, .rst,
    .func(in.func), .payload(in.payload), .seq_id(in.seq_id), .latency(in.latency),
    .capacity_in_use, .default_delay, .cmd, .sts,
    .out_payload(out.out_payload), .out_seq_id(out.out_seq_id), .status(out.status),
    .occupancy(out.occupancy), .queue_state(out.queue_state),
    .oldest_ready(out.oldest_ready), .oldest_ready_now(out.oldest_ready_now),
    .some_ready(out.some_ready), .some_ready_now(out.some_ready_now),
    .removed_count(out.removed_count)
  );

endmodule

/* rtl/tdpq_ctrl.sv */
module tdpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tdpq_pkg::sts_t sts,
  output tdpq_pkg::cmd_t cmd
);
  import tdpq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          // load also sets the scan pointer for the word
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (sts.func)
          FN_TICK: begin
            cmd.op_tick = 1'b1;
            cmd.scan_clr = 1'b1;
            state_next = S_FLAGS;
          end
          FN_PUSH_DEF, FN_PUSH_LAT: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.op_push = 1'b1;
            end
            cmd.scan_clr = 1'b1;
            state_next = S_FLAGS;
          end
          FN_FLUSH: begin
            state_next = S_FLUSH;
          end
          default: begin
            // pops: ptr walks to the chosen entry
            if (sts.hit) begin
              state_next = S_SHIFT;
            end else if (sts.scan_end) begin
              cmd.set_no_pop = 1'b1;
              cmd.scan_clr = 1'b1;
              state_next = S_FLAGS;
            end else begin
              cmd.scan_step = 1'b1;
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          cmd.shift_done = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = S_FLAGS;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.flush_hit) begin
          cmd.flush_step = 1'b1;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next = S_FLAGS;
        end
      end
      S_FLAGS: begin
        if (sts.scan_end) begin
          cmd.out_load = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/tdpq_dp.sv */
module tdpq_dp #(
  parameter int DEPTH = tdpq_pkg::DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = tdpq_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [2:0]               func,
  input  logic [31:0]              payload,
  input  logic [63:0]              seq_id,
  input  logic [9:0]               latency,
  input  logic [4:0]               capacity_in_use,
  input  logic [9:0]               default_delay,
  input  tdpq_pkg::cmd_t           cmd,
  output tdpq_pkg::sts_t           sts,
  output logic [31:0]              out_payload,
  output logic [63:0]              out_seq_id,
  output logic [1:0]               status,
  output logic [4:0]               occupancy,
  output logic [1:0]               queue_state,
  output logic                     oldest_ready,
  output logic                     oldest_ready_now,
  output logic                     some_ready,
  output logic                     some_ready_now,
  output logic [4:0]               removed_count
);
  import tdpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // entry store: payload, id, ready cycle
  logic [PAYLOAD_BITS-1:0] mem_pay [DEPTH];
  logic [ID_W-1:0]         mem_id  [DEPTH];
  logic [CYC_W-1:0]        mem_rc  [DEPTH];

  logic [CW-1:0]           count;
  logic [CYC_W-1:0]        now;
  logic [CW-1:0]           ptr;
  func_t                   fn;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic [ID_W-1:0]         in_id;
  logic [DLY_W-1:0]        in_lat;
  logic [1:0]              st;
  logic [CW-1:0]           removed;
  logic [PAYLOAD_BITS-1:0] pop_pay;
  logic [ID_W-1:0]         pop_id;
  logic                    s_r, s_rn;
  logic                    walk_flags;

  logic [AW-1:0]    pa, pn, tail;
  logic [CYC_W-1:0] rc_p;
  logic             le_p, eq_p;
  logic [CW:0]      cap_eff;
  logic             full_c;

  assign pa   = ptr[AW-1:0];
  assign pn   = pa + AW'(1);
  assign tail = AW'(count - CW'(1));
  assign rc_p = mem_rc[pa];
  assign le_p = (rc_p <= now);
  assign eq_p = (rc_p == now);

  always_comb begin
    if ({1'b0, capacity_in_use} > 6'(DEPTH)) begin
      cap_eff = (CW+1)'(DEPTH);
    end else begin
      cap_eff = (CW+1)'(capacity_in_use);
    end
  end
  assign full_c = ({1'b0, count} >= cap_eff);

  always_comb begin
    sts.func = fn;
    sts.empty = (count == '0);
    sts.full = full_c;
    sts.scan_end = (ptr >= count);
    priority case (fn)
      FN_POP_OLD:   sts.hit = (count != '0) && (ptr == '0) && le_p;
      FN_POP_RDY:   sts.hit = (ptr < count) && le_p;
      FN_POP_NOW:   sts.hit = (ptr < count) && eq_p;
      FN_POP_YOUNG: sts.hit = (count != '0) && (ptr == count - CW'(1));
      default:      sts.hit = 1'b0;
    endcase
    // pop oldest and pop youngest never walk: they only look at one slot
    if ((fn == FN_POP_OLD || fn == FN_POP_YOUNG) && !sts.hit && !walk_flags) begin
      sts.scan_end = 1'b1;
    end
    sts.shift_end = (ptr + CW'(1) >= count);
    sts.flush_hit = (count != '0) && (mem_id[tail] >= in_id);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn     <= func_t'(func);
      in_pay <= payload[PAYLOAD_BITS-1:0];
      in_id  <= seq_id;
      in_lat <= latency;
    end
    if (cmd.op_push) begin
      mem_pay[tail + AW'(1)] <= in_pay;
      mem_id[tail + AW'(1)]  <= in_id;
      mem_rc[tail + AW'(1)]  <= now + CYC_W'((fn == FN_PUSH_DEF) ? default_delay : in_lat);
    end
    if (cmd.shift_step) begin
      mem_pay[pa] <= mem_pay[pn];
      mem_id[pa]  <= mem_id[pn];
      mem_rc[pa]  <= mem_rc[pn];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      now <= '0;
      ptr <= '0;
      st <= ST_DONE;
      removed <= '0;
      s_r <= 1'b0;
      s_rn <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr <= (func_t'(func) == FN_POP_YOUNG) ? count - CW'(1) : '0;
        st <= ST_DONE;
        removed <= '0;
      end
      if (cmd.op_tick) now <= now + CYC_W'(1);
      if (cmd.op_push) count <= count + CW'(1);
      if (cmd.set_full) st <= ST_FULL;
      if (cmd.set_no_pop) st <= ST_NO_POP;
      if (cmd.scan_step) ptr <= ptr + CW'(1);
      if (cmd.shift_step) ptr <= ptr + CW'(1);
      if (cmd.shift_done) begin
        count <= count - CW'(1);
        removed <= CW'(1);
      end
      if (cmd.flush_step) begin
        count <= count - CW'(1);
        removed <= removed + CW'(1);
      end
      if (cmd.scan_clr) begin
        ptr <= '0;
        s_r <= 1'b0;
        s_rn <= 1'b0;
      end
      // flags pass: scan_step walks entries after the item is done
      if (cmd.scan_step && walk_flags && ptr < count) begin
        s_r <= s_r | le_p;
        s_rn <= s_rn | eq_p;
      end
    end
  end

  // capture popped entry when the scan lands on it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pop_pay <= '0;
      pop_id <= '0;
      walk_flags <= 1'b0;
    end else if (cmd.scan_clr) begin
      walk_flags <= 1'b1;
    end
    if (!walk_flags && sts.hit && !cmd.load && !cmd.shift_step && !cmd.shift_done) begin
      pop_pay <= mem_pay[pa];
      pop_id  <= mem_id[pa];
    end
  end

  logic fr, fo_r, fo_rn;
  assign fr = walk_flags && ptr < count;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_payload <= 32'(pop_pay);
      out_seq_id <= pop_id;
      status <= st;
      occupancy <= 5'(count);
      if (full_c) begin
        queue_state <= QS_FULL;
      end else if (count == '0) begin
        queue_state <= QS_EMPTY;
      end else begin
        queue_state <= QS_PART;
      end
      oldest_ready <= (count != '0) && fo_r;
      oldest_ready_now <= (count != '0) && fo_rn;
      some_ready <= s_r;
      some_ready_now <= s_rn;
      removed_count <= 5'(removed);
    end
  end

  // oldest flags sampled at slot 0 of the flags pass
  always_ff @(posedge clk) begin
    if (fr && ptr == '0) begin
      fo_r <= le_p;
      fo_rn <= eq_p;
    end
  end

endmodule

/* rtl/tdpq_check.sv */
module tdpq_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [4:0] removed_count,
  input logic [1:0] queue_state,
  input logic [4:0] occupancy
);
  import tdpq_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_no_pop_none_removed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_POP |-> removed_count == 5'd0)
    else $error("failed pop removed entries");

  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_state == QS_EMPTY |-> occupancy == 5'd0)
    else $error("empty with entries");

endmodule

bind timed_delay_port_queue tdpq_check u_check (
  .clk, .rst,
  .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .status(out.status), .removed_count(out.removed_count),
  .queue_state(out.queue_state), .occupancy(out.occupancy)
);

/* verif/tb_timed_delay_port_queue.sv */
module tb_timed_delay_port_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import tdpq_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [2:0] ADDR_CAP = {REG_CAP, 2'b00};
  localparam logic [2:0] ADDR_DLY = {REG_DLY, 2'b00};
  localparam int SETTLE = 60;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] pay;
    logic [63:0] id;
    status_t     st;
    logic [4:0]  occ;
    qstate_t     qs;
    logic        o_r;
    logic        o_rn;
    logic        s_r;
    logic        s_rn;
    logic [4:0]  removed;
  } port_result_t;

  typedef struct {
    func_t       fn;
    logic [31:0] pay;
    logic [63:0] id;
    logic [9:0]  lat;
    bit          fixed;
    status_t     st;
    logic [4:0]  occ;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tdpq_in_if in_ch();
  tdpq_out_if out_ch();

  timed_delay_port_queue dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the port
  logic [31:0] sh_pay [QDEPTH];
  logic [63:0] sh_id [QDEPTH];
  logic [63:0] sh_rdy [QDEPTH];
  int unsigned sh_held;
  logic [63:0] sh_now;
  logic [4:0] sh_cap;
  logic [9:0] sh_dly;

  port_result_t expected_words[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit idle_on = 1'b1;
  logic [63:0] next_id = 64'd100;

  function automatic port_result_t apply_word(func_t fn, logic [31:0] pay,
                                              logic [63:0] id, logic [9:0] lat);
    port_result_t r;
    int unsigned cap;
    int pick;
    r = '0;
    r.st = ST_DONE;
    cap = (sh_cap > QDEPTH) ? QDEPTH : sh_cap;
    pick = -1;
    case (fn)
      FN_TICK: sh_now = sh_now + 64'd1;
      FN_PUSH_DEF, FN_PUSH_LAT: begin
        if (sh_held >= cap) begin
          r.st = ST_FULL;
        end else begin
          sh_pay[sh_held] = pay;
          sh_id[sh_held] = id;
          sh_rdy[sh_held] = sh_now + ((fn == FN_PUSH_DEF) ? 64'(sh_dly) : 64'(lat));
          sh_held++;
        end
      end
      FN_POP_OLD: if (sh_held > 0 && sh_rdy[0] <= sh_now) pick = 0;
      FN_POP_RDY, FN_POP_NOW: begin
        for (int i = 0; i < sh_held; i++)
          if (pick < 0 && ((fn == FN_POP_RDY) ? sh_rdy[i] <= sh_now : sh_rdy[i] == sh_now))
            pick = i;
      end
      FN_POP_YOUNG: if (sh_held > 0) pick = sh_held - 1;
      default: begin
        while (sh_held > 0 && sh_id[sh_held-1] >= id) begin
          sh_held--;
          r.removed++;
        end
      end
    endcase
    if (fn inside {FN_POP_OLD, FN_POP_RDY, FN_POP_NOW, FN_POP_YOUNG}) begin
      if (pick < 0) begin
        r.st = ST_NO_POP;
      end else begin
        r.pay = sh_pay[pick];
        r.id = sh_id[pick];
        r.removed = 5'd1;
        for (int i = pick; i + 1 < sh_held; i++) begin
          sh_pay[i] = sh_pay[i+1];
          sh_id[i] = sh_id[i+1];
          sh_rdy[i] = sh_rdy[i+1];
        end
        sh_held--;
      end
    end
    if (sh_held > 0) begin
      r.o_r = sh_rdy[0] <= sh_now;
      r.o_rn = sh_rdy[0] == sh_now;
      for (int i = 0; i < sh_held; i++) begin
        if (sh_rdy[i] <= sh_now) r.s_r = 1'b1;
        if (sh_rdy[i] == sh_now) r.s_rn = 1'b1;
      end
    end
    r.occ = sh_held[4:0];
    r.qs = (sh_held >= cap) ? QS_FULL : (sh_held == 0) ? QS_EMPTY : QS_PART;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sender
  task automatic send_word(func_t fn, logic [31:0] pay, logic [63:0] id, logic [9:0] lat,
                           output port_result_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = fn;
    in_ch.payload = pay;
    in_ch.seq_id = id;
    in_ch.latency = lat;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_word(fn, pay, id, lat);
    expected_words = {expected_words, r};
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // receiver stall bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    port_result_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_timed_delay_port_queue: done, errors");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", out_ch.out_seq_id, 0);
      end else begin
        w = expected_words[0];
        expected_words.delete(0);
        if (out_ch.out_payload !== w.pay) report("out_payload", out_ch.out_payload, w.pay);
        if (out_ch.out_seq_id !== w.id) report("out_seq_id", out_ch.out_seq_id, w.id);
        if (out_ch.status !== w.st) report("status", out_ch.status, w.st);
        if (out_ch.occupancy !== w.occ) report("occupancy", out_ch.occupancy, w.occ);
        if (out_ch.queue_state !== w.qs) report("queue_state", out_ch.queue_state, w.qs);
        if (out_ch.oldest_ready !== w.o_r) report("oldest_ready", out_ch.oldest_ready, w.o_r);
        if (out_ch.oldest_ready_now !== w.o_rn)
          report("oldest_ready_now", out_ch.oldest_ready_now, w.o_rn);
        if (out_ch.some_ready !== w.s_r) report("some_ready", out_ch.some_ready, w.s_r);
        if (out_ch.some_ready_now !== w.s_rn)
          report("some_ready_now", out_ch.some_ready_now, w.s_rn);
        if (out_ch.removed_count !== w.removed)
          report("removed_count", out_ch.removed_count, w.removed);
      end
    end
  end

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_CAP) sh_cap = data[4:0];
    else sh_dly = data[9:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic random_word();
    port_result_t r;
    int unsigned sel;
    func_t fn;
    logic [63:0] id;
    logic [9:0] lat;
    sel = $urandom_range(0, 99);
    if (sel < 20) fn = FN_TICK;
    else if (sel < 35) fn = FN_PUSH_DEF;
    else if (sel < 52) fn = FN_PUSH_LAT;
    else if (sel < 62) fn = FN_POP_OLD;
    else if (sel < 72) fn = FN_POP_RDY;
    else if (sel < 80) fn = FN_POP_NOW;
    else if (sel < 90) fn = FN_POP_YOUNG;
    else if (sel < 96) fn = FN_FLUSH;
    else fn = func_t'($urandom_range(0, 7));
    if (fn == FN_FLUSH && sh_held > 0 && $urandom_range(0, 2) != 0) begin
      id = sh_id[$urandom_range(0, sh_held - 1)];
    end else if ($urandom_range(0, 7) == 0) begin
      id = {$urandom, $urandom};
    end else begin
      next_id = next_id + $urandom_range(1, 4);
      id = next_id;
    end
    lat = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
    send_word(fn, $urandom, id, lat, r);
  endtask

  stim_row_t rows [20] = '{
    '{FN_TICK,      32'h0,        64'h0,       10'd0,    1, ST_DONE,   5'd0},
    '{FN_POP_OLD,   32'h0,        64'h0,       10'd0,    1, ST_NO_POP, 5'd0},
    '{FN_POP_RDY,   32'h0,        64'h0,       10'd0,    1, ST_NO_POP, 5'd0},
    '{FN_POP_NOW,   32'h0,        64'h0,       10'd0,    1, ST_NO_POP, 5'd0},
    '{FN_POP_YOUNG, 32'h0,        64'h0,       10'd0,    1, ST_NO_POP, 5'd0},
    '{FN_FLUSH,     32'h0,        64'h0,       10'd0,    1, ST_DONE,   5'd0},
    '{FN_PUSH_DEF,  32'hFFFFFFFF, {64{1'b1}},  10'd0,    1, ST_DONE,   5'd1},
    '{FN_PUSH_LAT,  32'h0,        64'h0,       10'd0,    1, ST_DONE,   5'd2},
    '{FN_PUSH_LAT,  32'h5A5A5A5A, 64'h10,      10'd1023, 1, ST_DONE,   5'd3},
    '{FN_POP_OLD,   32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_POP_NOW,   32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_TICK,      32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_POP_NOW,   32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_POP_OLD,   32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_PUSH_DEF,  32'h12345678, 64'h20,      10'd5,    0, ST_DONE,   5'd0},
    '{FN_PUSH_LAT,  32'hA5A5A5A5, 64'h30,      10'd2,    0, ST_DONE,   5'd0},
    '{FN_TICK,      32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_POP_RDY,   32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_POP_YOUNG, 32'h0,        64'h0,       10'd0,    0, ST_DONE,   5'd0},
    '{FN_FLUSH,     32'h0,        64'h0,       10'd0,    1, ST_DONE,   5'd0}
  };

  initial begin
    port_result_t r;
    logic [31:0] cap_set [6] = '{32'd4, 32'd1, 32'd0, 32'd31, 32'd16, 32'd8};
    logic [31:0] dly_set [6] = '{32'd0, 32'd1023, 32'd3, 32'd1, 32'd2, 32'd1};
    in_ch.valid = 1'b0;
    in_ch.func = FN_TICK;
    in_ch.payload = '0;
    in_ch.seq_id = '0;
    in_ch.latency = '0;
    out_ch.ready = 1'b0;
    sh_held = 0;
    sh_now = '0;
    sh_cap = 5'd16;
    sh_dly = 10'd1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[k]) begin
      send_word(rows[k].fn, rows[k].pay, rows[k].id, rows[k].lat, r);
      // after-reset and error rows are known by heart
      if (rows[k].fixed && (r.st !== rows[k].st || r.occ !== rows[k].occ))
        report("directed row", k, r.st);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ADDR_CAP, cap_set[ph]);
      write_reg(ADDR_DLY, dly_set[ph]);
      if (ph == 5) idle_on = 1'b0;
      repeat (75) random_word();
    end

    drain();
    if (errors == 0) begin
      $display("tb_timed_delay_port_queue: done, clean");
    end else begin
      $display("tb_timed_delay_port_queue: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tdpq_pkg.sv
rtl/tdpq_if.sv
rtl/tdpq_ctrl.sv
rtl/tdpq_dp.sv
rtl/timed_delay_port_queue.sv
rtl/tdpq_check.sv
verif/tb_timed_delay_port_queue.sv
